// ===== rtl/huffman_code_builder_macros.svh =====
// ----------------------------------------------------------------------------
// Huffman code builder assertion macros
// Shared concurrent assertion forms, clocked on i_clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_CODE_BUILDER_MACROS_SVH
`define HUFFMAN_CODE_BUILDER_MACROS_SVH

// same-cycle implication
`define HCB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hcb assertion failed");

// next-cycle implication
`define HCB_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hcb assertion failed");

`endif

// ===== rtl/hcb_pkg.sv =====
// ----------------------------------------------------------------------------
// hcb_pkg
// Types, widths and command codes shared by the Huffman code builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hcb_pkg;

    localparam int WEIGHT_W   = 40;
    localparam int CODE_W     = 64;
    localparam int LEN_W      = 7;
    localparam int DEPTH_W    = 9;
    localparam int SYM_IN_W   = 8;
    localparam int FUNC_W     = 2;
    localparam int IN_DATA_W  = 8;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 112;
    localparam int OUT_USER_W = 2;

    localparam logic [FUNC_W-1:0] F_COUNT = 2'd0;
    localparam logic [FUNC_W-1:0] F_BUILD = 2'd1;
    localparam logic [FUNC_W-1:0] F_QUERY = 2'd2;
    localparam logic [FUNC_W-1:0] F_CLEAR = 2'd3;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_TAKE,
        OP_CLEAR,
        OP_IGNORE,
        OP_CNT_RD,
        OP_CNT_WR,
        OP_Q_RD,
        OP_Q_DO,
        OP_B_INIT,
        OP_LF_RD,
        OP_LF_WR,
        OP_I_INIT,
        OP_J_INIT,
        OP_SC_RD,
        OP_SC_EV,
        OP_JN_W0,
        OP_JN_W1,
        OP_JN_W2,
        OP_CD_INIT,
        OP_CD_START,
        OP_CD_RD,
        OP_CD_EV,
        OP_DONE
    } t_op;

    typedef struct packed {
        t_op  op;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              built;
        logic              sym_ok;
        logic              leaf_last;
        logic              join_done;
        logic              scan_last;
        logic              node_root;
        logic              code_done;
        logic              out_busy;
    } t_sts;

endpackage

// ===== rtl/hcb_datapath.sv =====
// ----------------------------------------------------------------------------
// hcb_datapath
// Count, node, leaf and code memories, minimum scan and code walk logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcb_datapath #(
    parameter int SYMBOL_COUNT = 256,
    parameter int COUNT_BITS   = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  hcb_pkg::t_cmd                   i_cmd,
    output hcb_pkg::t_sts                   o_sts,
    input  logic [hcb_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,  // symbol
    input  logic [hcb_pkg::IN_USER_W-1:0]   i_s_axis_tuser,  // func
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [hcb_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,  // code_bits, code_length, weight
    output logic [hcb_pkg::OUT_USER_W-1:0]  o_m_axis_tuser   // present, status
);
    import hcb_pkg::*;

    localparam int SYM_W   = $clog2(SYMBOL_COUNT);
    localparam int NODE_W  = SYM_W + 1;
    localparam int NODE_N  = 2 * SYMBOL_COUNT - 1;
    localparam int NREC_W  = WEIGHT_W + NODE_W + 1;
    localparam int CREC_W  = CODE_W + LEN_W;
    localparam logic [NODE_W-1:0] NO_NODE = NODE_W'(NODE_N);

    logic [COUNT_BITS-1:0] cnt_mem  [SYMBOL_COUNT];
    logic [NREC_W-1:0]     node_mem [NODE_N];
    logic [SYM_W-1:0]      leaf_mem [SYMBOL_COUNT];
    logic [CREC_W-1:0]     code_mem [SYMBOL_COUNT];

    logic [SYMBOL_COUNT-1:0] r_cnt_vld;
    logic                    r_built;
    logic                    r_ovalid;

    logic [FUNC_W-1:0]     r_func;
    logic [SYM_IN_W-1:0]   r_sym;
    logic [COUNT_BITS-1:0] r_cnt_q;
    logic                  r_cnt_vq;
    logic [NREC_W-1:0]     r_node_q;
    logic [SYM_W-1:0]      r_leaf_q;
    logic [CREC_W-1:0]     r_code_q;

    logic [SYM_W-1:0]    r_sj;
    logic [NODE_W-1:0]   r_n;
    logic [NODE_W-1:0]   r_i;
    logic [NODE_W-1:0]   r_nj;
    logic [NODE_W-1:0]   r_k;
    logic [NODE_W-1:0]   r_a;
    logic [NODE_W-1:0]   r_b;
    logic [NODE_W-1:0]   r_cur;
    logic [WEIGHT_W-1:0] r_w1;
    logic [WEIGHT_W-1:0] r_w2;
    logic                r_have1;
    logic                r_have2;
    logic [WEIGHT_W-1:0] r_root;
    logic [DEPTH_W-1:0]  r_depth;
    logic [CODE_W-1:0]   r_acc;

    logic [CODE_W-1:0]   r_res_code;
    logic [LEN_W-1:0]    r_res_len;
    logic [WEIGHT_W-1:0] r_res_weight;
    logic                r_res_present;
    logic                r_res_status;

    logic [CODE_W-1:0]   r_o_code;
    logic [LEN_W-1:0]    r_o_len;
    logic [WEIGHT_W-1:0] r_o_weight;
    logic                r_o_present;
    logic                r_o_status;

    logic [SYM_W-1:0]      sa;
    logic [SYM_W-1:0]      cnt_addr;
    logic [COUNT_BITS-1:0] cnt_val;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic                  cnt_nz;
    logic [WEIGHT_W-1:0]   nd_w;
    logic [NODE_W-1:0]     nd_parent;
    logic                  nd_right;
    logic                  nd_free;
    logic [WEIGHT_W:0]     sum;
    logic [WEIGHT_W-1:0]   sum_sat;
    logic                  a_left;
    logic [LEN_W-1:0]      len_sat;

    assign sa       = r_sym[SYM_W-1:0];
    assign cnt_addr = (i_cmd.op == OP_LF_RD) ? r_sj : sa;
    assign cnt_val  = r_cnt_vq ? r_cnt_q : '0;
    assign cnt_nz   = |cnt_val;
    assign cnt_inc  = (&cnt_val) ? cnt_val : cnt_val + COUNT_BITS'(1);

    assign nd_w      = r_node_q[NREC_W-1 -: WEIGHT_W];
    assign nd_parent = r_node_q[NODE_W:1];
    assign nd_right  = r_node_q[0];
    assign nd_free   = (nd_parent == NO_NODE);

    assign sum     = {1'b0, r_w1} + {1'b0, r_w2};
    assign sum_sat = sum[WEIGHT_W] ? '1 : sum[WEIGHT_W-1:0];
    assign a_left  = (r_w1 < r_w2) || ((r_w1 == r_w2) && (r_a < r_b));
    assign len_sat = (r_depth > DEPTH_W'(CODE_W)) ? LEN_W'(CODE_W) : r_depth[LEN_W-1:0];

    always_comb begin
        o_sts.func      = r_func;
        o_sts.built     = r_built;
        o_sts.sym_ok    = ({1'b0, r_sym} < (SYM_IN_W + 1)'(SYMBOL_COUNT));
        o_sts.leaf_last = (r_sj == SYM_W'(SYMBOL_COUNT - 1));
        o_sts.join_done = (({1'b0, r_i} + (NODE_W + 1)'(1)) >= {r_n, 1'b0});
        o_sts.scan_last = (({1'b0, r_nj} + (NODE_W + 1)'(1)) == {1'b0, r_i});
        o_sts.node_root = nd_free;
        o_sts.code_done = (r_k == r_n);
        o_sts.out_busy  = r_ovalid & ~i_m_axis_tready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_vld <= '0;
            r_built   <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cmd.op == OP_CLEAR) begin
                r_cnt_vld <= '0;
                r_built   <= 1'b0;
            end
            if (i_cmd.op == OP_CNT_WR) begin
                r_cnt_vld[sa] <= 1'b1;
            end
            if (i_cmd.op == OP_DONE) begin
                r_built <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_CNT_WR) begin
            cnt_mem[sa] <= cnt_inc;
        end
        if ((i_cmd.op == OP_CNT_RD) || (i_cmd.op == OP_Q_RD) || (i_cmd.op == OP_LF_RD)) begin
            r_cnt_q  <= cnt_mem[cnt_addr];
            r_cnt_vq <= r_cnt_vld[cnt_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        priority case (i_cmd.op)
            OP_LF_WR: begin
                if (cnt_nz) begin
                    node_mem[r_n] <= {WEIGHT_W'(cnt_val), NO_NODE, 1'b0};
                end
            end
            OP_JN_W0: node_mem[r_i] <= {sum_sat, NO_NODE, 1'b0};
            OP_JN_W1: node_mem[r_a] <= {r_w1, r_i, ~a_left};
            OP_JN_W2: node_mem[r_b] <= {r_w2, r_i, a_left};
            default: ;
        endcase
        if (i_cmd.op == OP_SC_RD) begin
            r_node_q <= node_mem[r_nj];
        end else if (i_cmd.op == OP_CD_RD) begin
            r_node_q <= node_mem[r_cur];
        end
    end

    always_ff @(posedge i_clk) begin
        if ((i_cmd.op == OP_LF_WR) && cnt_nz) begin
            leaf_mem[r_n[SYM_W-1:0]] <= r_sj;
        end
        if (i_cmd.op == OP_CD_RD) begin
            r_leaf_q <= leaf_mem[r_k[SYM_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if ((i_cmd.op == OP_CD_EV) && nd_free) begin
            code_mem[r_leaf_q] <= {r_acc, len_sat};
        end
        if (i_cmd.op == OP_Q_RD) begin
            r_code_q <= code_mem[sa];
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_TAKE: begin
                r_func        <= i_s_axis_tuser[FUNC_W-1:0];
                r_sym         <= i_s_axis_tdata[SYM_IN_W-1:0];
                r_res_code    <= '0;
                r_res_len     <= '0;
                r_res_weight  <= '0;
                r_res_present <= 1'b0;
                r_res_status  <= 1'b0;
            end
            OP_IGNORE: r_res_status <= 1'b1;
            OP_CNT_WR: r_res_weight <= WEIGHT_W'(cnt_inc);
            OP_Q_DO: begin
                r_res_weight  <= WEIGHT_W'(cnt_val);
                r_res_present <= cnt_nz;
                if (cnt_nz) begin
                    r_res_code <= r_code_q[CREC_W-1 -: CODE_W];
                    r_res_len  <= r_code_q[LEN_W-1:0];
                end
            end
            OP_B_INIT: begin
                r_sj   <= '0;
                r_n    <= '0;
                r_root <= '0;
            end
            OP_LF_WR: begin
                if (cnt_nz) begin
                    r_n    <= r_n + NODE_W'(1);
                    r_root <= WEIGHT_W'(cnt_val);
                end
                r_sj <= r_sj + SYM_W'(1);
            end
            OP_I_INIT: r_i <= r_n;
            OP_J_INIT: begin
                r_nj    <= '0;
                r_have1 <= 1'b0;
                r_have2 <= 1'b0;
            end
            OP_SC_EV: begin
                if (nd_free) begin
                    if (!r_have1 || (nd_w < r_w1)) begin
                        r_w2    <= r_w1;
                        r_b     <= r_a;
                        r_have2 <= r_have1;
                        r_w1    <= nd_w;
                        r_a     <= r_nj;
                        r_have1 <= 1'b1;
                    end else if (!r_have2 || (nd_w < r_w2)) begin
                        r_w2    <= nd_w;
                        r_b     <= r_nj;
                        r_have2 <= 1'b1;
                    end
                end
                r_nj <= r_nj + NODE_W'(1);
            end
            OP_JN_W0: r_root <= sum_sat;
            OP_JN_W2: r_i <= r_i + NODE_W'(1);
            OP_CD_INIT: r_k <= '0;
            OP_CD_START: begin
                r_cur   <= r_k;
                r_depth <= '0;
                r_acc   <= '0;
            end
            OP_CD_EV: begin
                if (!nd_free) begin
                    if ((r_depth < DEPTH_W'(CODE_W)) && nd_right) begin
                        r_acc <= r_acc | (CODE_W'(1) << r_depth[$clog2(CODE_W)-1:0]);
                    end
                    r_depth <= r_depth + DEPTH_W'(1);
                    r_cur   <= nd_parent;
                end else begin
                    r_k <= r_k + NODE_W'(1);
                end
            end
            OP_DONE: r_res_weight <= r_root;
            default: ;
        endcase
        if (i_cmd.out_load) begin
            r_o_code    <= r_res_code;
            r_o_len     <= r_res_len;
            r_o_weight  <= r_res_weight;
            r_o_present <= r_res_present;
            r_o_status  <= r_res_status;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {1'b0, r_o_weight, r_o_len, r_o_code};
    assign o_m_axis_tuser  = {r_o_status, r_o_present};

endmodule

// ===== rtl/hcb_ctrl.sv =====
// ----------------------------------------------------------------------------
// hcb_ctrl
// Command sequencer: decode, count, query, clear, tree build and code walk phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "huffman_code_builder_macros.svh"

module hcb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_valid,
    output logic          o_s_ready,
    input  hcb_pkg::t_sts i_sts,
    output hcb_pkg::t_cmd o_cmd
);
    import hcb_pkg::*;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_DEC     = 5'd1;
    localparam logic [4:0] S_CNT_WR  = 5'd2;
    localparam logic [4:0] S_Q_DO    = 5'd3;
    localparam logic [4:0] S_LF_RD   = 5'd4;
    localparam logic [4:0] S_LF_WR   = 5'd5;
    localparam logic [4:0] S_J_FIRST = 5'd6;
    localparam logic [4:0] S_J_CHK   = 5'd7;
    localparam logic [4:0] S_SC_RD   = 5'd8;
    localparam logic [4:0] S_SC_EV   = 5'd9;
    localparam logic [4:0] S_JN_W0   = 5'd10;
    localparam logic [4:0] S_JN_W1   = 5'd11;
    localparam logic [4:0] S_JN_W2   = 5'd12;
    localparam logic [4:0] S_CD_CHK  = 5'd13;
    localparam logic [4:0] S_CD_RD   = 5'd14;
    localparam logic [4:0] S_CD_EV   = 5'd15;
    localparam logic [4:0] S_FIN     = 5'd16;

    logic [4:0] r_state;
    logic [4:0] n_state;

    assign o_s_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd.op       = OP_NONE;
        o_cmd.out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.op = OP_TAKE;
                    n_state  = S_DEC;
                end
            end
            S_DEC: begin
                unique case (i_sts.func)
                    F_COUNT: begin
                        priority if (i_sts.built) begin
                            o_cmd.op = OP_IGNORE;
                            n_state  = S_FIN;
                        end else if (!i_sts.sym_ok) begin
                            n_state = S_FIN;
                        end else begin
                            o_cmd.op = OP_CNT_RD;
                            n_state  = S_CNT_WR;
                        end
                    end
                    F_BUILD: begin
                        o_cmd.op = OP_B_INIT;
                        n_state  = S_LF_RD;
                    end
                    F_QUERY: begin
                        priority if (!i_sts.built) begin
                            o_cmd.op = OP_IGNORE;
                            n_state  = S_FIN;
                        end else if (!i_sts.sym_ok) begin
                            n_state = S_FIN;
                        end else begin
                            o_cmd.op = OP_Q_RD;
                            n_state  = S_Q_DO;
                        end
                    end
                    F_CLEAR: begin
                        o_cmd.op = OP_CLEAR;
                        n_state  = S_FIN;
                    end
                    default: n_state = S_FIN;
                endcase
            end
            S_CNT_WR: begin
                o_cmd.op = OP_CNT_WR;
                n_state  = S_FIN;
            end
            S_Q_DO: begin
                o_cmd.op = OP_Q_DO;
                n_state  = S_FIN;
            end
            S_LF_RD: begin
                o_cmd.op = OP_LF_RD;
                n_state  = S_LF_WR;
            end
            S_LF_WR: begin
                o_cmd.op = OP_LF_WR;
                n_state  = i_sts.leaf_last ? S_J_FIRST : S_LF_RD;
            end
            S_J_FIRST: begin
                o_cmd.op = OP_I_INIT;
                n_state  = S_J_CHK;
            end
            S_J_CHK: begin
                if (i_sts.join_done) begin
                    o_cmd.op = OP_CD_INIT;
                    n_state  = S_CD_CHK;
                end else begin
                    o_cmd.op = OP_J_INIT;
                    n_state  = S_SC_RD;
                end
            end
            S_SC_RD: begin
                o_cmd.op = OP_SC_RD;
                n_state  = S_SC_EV;
            end
            S_SC_EV: begin
                o_cmd.op = OP_SC_EV;
                n_state  = i_sts.scan_last ? S_JN_W0 : S_SC_RD;
            end
            S_JN_W0: begin
                o_cmd.op = OP_JN_W0;
                n_state  = S_JN_W1;
            end
            S_JN_W1: begin
                o_cmd.op = OP_JN_W1;
                n_state  = S_JN_W2;
            end
            S_JN_W2: begin
                o_cmd.op = OP_JN_W2;
                n_state  = S_J_CHK;
            end
            S_CD_CHK: begin
                if (i_sts.code_done) begin
                    o_cmd.op = OP_DONE;
                    n_state  = S_FIN;
                end else begin
                    o_cmd.op = OP_CD_START;
                    n_state  = S_CD_RD;
                end
            end
            S_CD_RD: begin
                o_cmd.op = OP_CD_RD;
                n_state  = S_CD_EV;
            end
            S_CD_EV: begin
                o_cmd.op = OP_CD_EV;
                n_state  = i_sts.node_root ? S_CD_CHK : S_CD_RD;
            end
            S_FIN: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    `HCB_ASSERT_IMP(a_load_when_free, o_cmd.out_load, !i_sts.out_busy)
    `HCB_ASSERT_NXT(a_take_to_decode, i_s_valid && o_s_ready, r_state == S_DEC)
    `HCB_ASSERT_IMP(a_count_unbuilt, r_state == S_CNT_WR, !i_sts.built && i_sts.sym_ok)

endmodule

// ===== rtl/huffman_code_builder.sv =====
// ----------------------------------------------------------------------------
// huffman_code_builder
// Byte histogram with Huffman tree construction and code lookup.
// ----------------------------------------------------------------------------
// Input stream: tuser carries the command (count, build, query, clear) and
// tdata the byte symbol. Output stream returns one transaction per command:
// tdata holds code bits, code length and weight; tuser holds present and
// status flags.
// Count and query pass through decode with memory read, update and output
// load before the result is valid; clear and ignored commands skip the update.
// Build runs the leaf pass (a read and a write step per symbol slot), then for
// each join a check step, a scan over all existing nodes (a read and an
// evaluate step per node) through the single node memory port and three write
// steps, then for each leaf a start step and a read and an evaluate step per
// node on its path up to the root; the node memory port sets the build's pace.
// One command is worked at a time; the next is accepted as soon as the
// previous result sits in the output register, even if not yet taken.
// Reset clears counts (by per-symbol valid bits, no clearing pass), the
// built flag and the output valid. A stalled receiver holds the output
// transaction; a finished command waits for the output register to free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module huffman_code_builder #(
    parameter int SYMBOL_COUNT = 256,
    parameter int COUNT_BITS   = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [hcb_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,  // symbol
    input  logic [hcb_pkg::IN_USER_W-1:0]   i_s_axis_tuser,  // func
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [hcb_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,  // code_bits, code_length, weight
    output logic [hcb_pkg::OUT_USER_W-1:0]  o_m_axis_tuser   // present, status
);
    import hcb_pkg::*;

    t_cmd cmd;
    t_sts sts;

    hcb_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    hcb_datapath #(
        .SYMBOL_COUNT (SYMBOL_COUNT),
        .COUNT_BITS   (COUNT_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

// ===== tb/huffman_code_builder_tb.sv =====
// ----------------------------------------------------------------------------
// huffman_code_builder_tb
// Drives count, build, query and clear commands into the code builder,
// predicts every result with a local histogram and tree builder, and checks
// each output transaction field by field in order, under random idling but for the final rounds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module huffman_code_builder_tb;
    import hcb_pkg::*;

    localparam int NODES      = 511;
    localparam int NO_PARENT  = 511;
    localparam int CYCLE_CAP  = 3000000;
    localparam int DRAIN_WAIT = 40;

    typedef struct packed {
        logic [CODE_W-1:0]   code;
        logic [LEN_W-1:0]    len;
        logic [WEIGHT_W-1:0] weight;
        logic                present;
        logic                status;
    } t_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic [IN_DATA_W-1:0]  s_data = '0;
    logic [IN_USER_W-1:0]  s_user = '0;
    logic                  s_ready;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [OUT_DATA_W-1:0] m_data;
    logic [OUT_USER_W-1:0] m_user;

    t_result expected_results[$];
    int      errors = 0;
    int      cycles = 0;
    bit      idle_en = 1'b1;
    int      stall_left = 0;

    logic [31:0]         hist[256];
    bit                  tree_built;
    logic [CODE_W-1:0]   sym_code[256];
    logic [LEN_W-1:0]    sym_len[256];
    logic [WEIGHT_W-1:0] node_w[NODES];
    int                  node_up[NODES];
    int                  node_lo[NODES];
    int                  node_hi[NODES];

    huffman_code_builder uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),  // symbol
        .i_s_axis_tuser  (s_user),  // func
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),  // code_bits, code_length, weight
        .o_m_axis_tuser  (m_user)   // present, status
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic void clear_histogram();
        for (int s = 0; s < 256; s++) begin
            hist[s] = '0;
            sym_code[s] = '0;
            sym_len[s] = '0;
        end
        tree_built = 1'b0;
    endfunction

    function automatic logic [WEIGHT_W-1:0] build_huffman_codes();
        int leaf_sym[256];
        int n;
        int a, b, node, depth;
        bit have_a, have_b;
        logic [WEIGHT_W-1:0] wa, wb, w;
        logic [WEIGHT_W:0] sum;
        logic [CODE_W-1:0] word;
        n = 0;
        for (int s = 0; s < 256; s++) begin
            sym_code[s] = '0;
            sym_len[s] = '0;
            if (hist[s] != 0) begin
                leaf_sym[n] = s;
                node_w[n] = WEIGHT_W'(hist[s]);
                node_up[n] = NO_PARENT;
                node_lo[n] = NO_PARENT;
                node_hi[n] = NO_PARENT;
                n++;
            end
        end
        if (n == 0)
            return '0;
        for (int i = n; i < 2 * n - 1; i++) begin
            have_a = 0; have_b = 0; a = 0; b = 0; wa = '0; wb = '0;
            for (int j = 0; j < i; j++) begin
                if (node_up[j] != NO_PARENT)
                    continue;
                w = node_w[j];
                if (!have_a || w < wa) begin
                    wb = wa; b = a; have_b = have_a;
                    wa = w; a = j; have_a = 1;
                end else if (!have_b || w < wb) begin
                    wb = w; b = j; have_b = 1;
                end
            end
            sum = {1'b0, wa} + {1'b0, wb};
            node_w[i] = sum[WEIGHT_W] ? '1 : sum[WEIGHT_W-1:0];
            node_up[i] = NO_PARENT;
            node_up[a] = i;
            node_up[b] = i;
            if (wa < wb || (wa == wb && a < b)) begin
                node_lo[i] = a; node_hi[i] = b;
            end else begin
                node_lo[i] = b; node_hi[i] = a;
            end
        end
        for (int k = 0; k < n; k++) begin
            node = k; depth = 0; word = '0;
            while (node_up[node] != NO_PARENT) begin
                if (depth < 64 && node_hi[node_up[node]] == node)
                    word[depth] = 1'b1;
                depth++;
                node = node_up[node];
            end
            sym_code[leaf_sym[k]] = word;
            sym_len[leaf_sym[k]] = LEN_W'(depth > 64 ? 64 : depth);
        end
        return node_w[2 * n - 2];
    endfunction

    function automatic t_result predict_result(logic [FUNC_W-1:0] func, logic [7:0] sym);
        t_result r;
        r = '0;
        case (func)
            F_COUNT: begin
                if (tree_built) begin
                    r.status = 1'b1;
                end else begin
                    if (hist[sym] != 32'hFFFF_FFFF)
                        hist[sym] = hist[sym] + 1;
                    r.weight = WEIGHT_W'(hist[sym]);
                end
            end
            F_BUILD: begin
                r.weight = build_huffman_codes();
                tree_built = 1'b1;
            end
            F_QUERY: begin
                if (!tree_built) begin
                    r.status = 1'b1;
                end else begin
                    r.weight = WEIGHT_W'(hist[sym]);
                    r.present = hist[sym] != 0;
                    if (r.present) begin
                        r.code = sym_code[sym];
                        r.len = sym_len[sym];
                    end
                end
            end
            default: clear_histogram();
        endcase
        return r;
    endfunction

    task automatic send_cmd(logic [FUNC_W-1:0] func, logic [7:0] sym);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data <= sym;
        s_user <= func;
        do @(negedge i_clk); while (!s_ready);
        @(posedge i_clk);
        expected_results.push_back(predict_result(func, sym));
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_en && $urandom_range(0, 4) == 0) begin
            m_ready <= 1'b0;
            stall_left <= $urandom_range(0, 3);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_result want, got;
        if (i_rst_n && m_valid && m_ready) begin
            got.code = m_data[63:0];
            got.len = m_data[70:64];
            got.weight = m_data[110:71];
            got.present = m_user[0];
            got.status = m_user[1];
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected transaction %h", $time, got);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (got.code !== want.code) begin
                    $display("%0t: code_bits exp %h got %h", $time, want.code, got.code);
                    errors++;
                end
                if (got.len !== want.len) begin
                    $display("%0t: code_length exp %0d got %0d", $time, want.len, got.len);
                    errors++;
                end
                if (got.weight !== want.weight) begin
                    $display("%0t: weight exp %0d got %0d", $time, want.weight, got.weight);
                    errors++;
                end
                if (got.present !== want.present) begin
                    $display("%0t: present exp %b got %b", $time, want.present, got.present);
                    errors++;
                end
                if (got.status !== want.status) begin
                    $display("%0t: status exp %b got %b", $time, want.status, got.status);
                    errors++;
                end
                if (m_data[111] !== 1'b0) begin
                    $display("%0t: pad bit exp 0 got %b", $time, m_data[111]);
                    errors++;
                end
            end
        end
    end

    task automatic test_directed();
        send_cmd(F_QUERY, 8'd0);
        send_cmd(F_COUNT, 8'd0);
        send_cmd(F_COUNT, 8'd255);
        send_cmd(F_COUNT, 8'h55);
        send_cmd(F_COUNT, 8'hAA);
        send_cmd(F_COUNT, 8'd0);
        send_cmd(F_COUNT, 8'd0);
        send_cmd(F_COUNT, 8'd255);
        send_cmd(F_BUILD, 8'hFF);
        send_cmd(F_QUERY, 8'd0);
        send_cmd(F_QUERY, 8'd255);
        send_cmd(F_QUERY, 8'h55);
        send_cmd(F_QUERY, 8'hAA);
        send_cmd(F_QUERY, 8'd1);
        send_cmd(F_COUNT, 8'd1);
        send_cmd(F_BUILD, 8'd0);
        send_cmd(F_QUERY, 8'd0);
        send_cmd(F_CLEAR, 8'hFF);
        send_cmd(F_BUILD, 8'd0);
        send_cmd(F_QUERY, 8'd3);
        send_cmd(F_CLEAR, 8'd0);
        send_cmd(F_COUNT, 8'd7);
        send_cmd(F_COUNT, 8'd7);
        send_cmd(F_BUILD, 8'd0);
        send_cmd(F_QUERY, 8'd7);
        wait_idle();
    endtask

    // Well-formed rounds: clear, skewed histogram over a small alphabet, build,
    // queries. Noise commands are mixed in at a low rate.
    task automatic run_round(int alphabet, int counts);
        logic [7:0] syms[16];
        int pick;
        send_cmd(F_CLEAR, 8'($urandom));
        for (int i = 0; i < alphabet; i++)
            syms[i] = 8'($urandom);
        for (int i = 0; i < counts; i++) begin
            pick = $urandom_range(0, alphabet - 1);
            pick = $urandom_range(0, pick);
            if ($urandom_range(0, 19) == 0)
                send_cmd(F_QUERY, 8'($urandom));
            else
                send_cmd(F_COUNT, syms[pick]);
        end
        send_cmd(F_BUILD, 8'($urandom));
        for (int i = 0; i < alphabet + 2; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_cmd(F_COUNT, 8'($urandom));
            else if ($urandom_range(0, 4) == 0)
                send_cmd(F_QUERY, 8'($urandom));
            else
                send_cmd(F_QUERY, syms[$urandom_range(0, alphabet - 1)]);
        end
        if ($urandom_range(0, 3) == 0)
            send_cmd(F_BUILD, 8'($urandom));
    endtask

    task automatic test_random_rounds(int rounds);
        for (int r = 0; r < rounds; r++)
            run_round($urandom_range(1, 16), $urandom_range(4, 40));
        wait_idle();
    endtask

    task automatic test_full_alphabet();
        send_cmd(F_CLEAR, 8'd0);
        for (int s = 0; s < 256; s++)
            send_cmd(F_COUNT, 8'(s));
        for (int i = 0; i < 40; i++)
            send_cmd(F_COUNT, 8'($urandom_range(0, 15)));
        send_cmd(F_BUILD, 8'd0);
        for (int i = 0; i < 30; i++)
            send_cmd(F_QUERY, 8'($urandom));
        send_cmd(F_QUERY, 8'd0);
        send_cmd(F_QUERY, 8'd255);
        wait_idle();
    endtask

    task automatic test_deep_tree();
        send_cmd(F_CLEAR, 8'd0);
        for (int k = 0; k < 7; k++)
            repeat (1 << k) send_cmd(F_COUNT, 8'(k * 29));
        send_cmd(F_BUILD, 8'd0);
        for (int k = 0; k < 7; k++)
            send_cmd(F_QUERY, 8'(k * 29));
        wait_idle();
    endtask

    initial begin
        clear_histogram();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_deep_tree();
        test_random_rounds(6);
        test_full_alphabet();
        test_random_rounds(2);
        idle_en = 1'b0;
        test_random_rounds(2);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/hcb_pkg.sv
rtl/hcb_datapath.sv
rtl/hcb_ctrl.sv
rtl/huffman_code_builder.sv
tb/huffman_code_builder_tb.sv
